FILE: sv/spectrum_histogram_accumulator_defines.svh
// Assertion macros used by the checker file.
`ifndef SPECTRUM_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define SPECTRUM_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define SHA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sha_checker: same-cycle property failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sha_checker: next-cycle property failed");

`endif

FILE: sv/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

    // Default sizing of the bin store
    localparam int SHA_CHANNELS  = 1024;
    localparam int SHA_BIN_WIDTH = 48;

    // Register reset values
    localparam logic [10:0] SHA_DEF_CHANNEL_COUNT = 11'd1000;

    // Port field widths
    localparam int CHAN_W      = 10;
    localparam int AMOUNT_W    = 32;
    localparam int ACTION_W    = 3;
    localparam int COUNT_W     = 11;
    localparam int RESULT_W    = 48;
    localparam int S_TDATA_W   = 48;
    localparam int CFG_INDEX_W = 2;

    // Result range
    localparam logic signed [RESULT_W-1:0] OUT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] OUT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_ACC   = 3'd0,
        ACT_SET   = 3'd1,
        ACT_READ  = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_MAX   = 3'd4
    } act_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_COUNT  = 2'd1
    } reg_idx_t;

endpackage

FILE: sv/sha_ram.sv
`timescale 1ns / 1ps

module sha_ram
    import sha_pkg::*;
#(
    parameter int WIDTH = SHA_BIN_WIDTH,
    parameter int DEPTH = SHA_CHANNELS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/spectrum_histogram_accumulator.sv
`timescale 1ns / 1ps
// Set, dropped accumulate, out-of-range read and unknown actions go straight to ST_DONE; others
// pass ST_ACC (accumulate), ST_READ (read), a ST_CLEAR sweep (clear) or a ST_SCAN pass (max).
// One request at a time, a new one taken on the cycle after its result is staged.
// Bins live in one single-port-write RAM with registered read; accumulate is read-modify-write.
// Reset (aresetn, synchronous, active low) runs a clearing pass over the RAM, during which
// s_tready stays low; configuration writes are taken at all times.
module spectrum_histogram_accumulator
    import sha_pkg::*;
#(
    parameter int CHANNELS  = SHA_CHANNELS,
    parameter int BIN_WIDTH = SHA_BIN_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [9:0] channel, [41:10] amount, rest zero
    input  logic [ACTION_W-1:0]    s_tuser,   // [2:0] action
    // Results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RESULT_W-1:0]    m_tdata,   // [47:0] result_value
    output logic                   m_tuser,   // [0] ignored
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data
);

    localparam int AW   = $clog2(CHANNELS);
    localparam int CW   = AW + 1;
    localparam int CNTW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int EW   = ((BIN_WIDTH > AMOUNT_W) ? BIN_WIDTH : AMOUNT_W) + 1;
    localparam int OXW  = (BIN_WIDTH > RESULT_W) ? BIN_WIDTH : RESULT_W;

    localparam logic signed [BIN_WIDTH-1:0] BIN_MAX = {1'b0, {(BIN_WIDTH-1){1'b1}}};
    localparam logic signed [BIN_WIDTH-1:0] BIN_MIN = {1'b1, {(BIN_WIDTH-1){1'b0}}};
    localparam logic [AW-1:0]               LAST_ADDR = AW'(CHANNELS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic                         enable_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [CW-1:0]                idx_reg;
    logic                         clr_emit_reg;
    logic                         first_reg;
    logic [AW-1:0]                addr_reg;
    logic signed [AMOUNT_W-1:0]   amount_reg;
    logic signed [BIN_WIDTH-1:0]  value_reg;
    logic                         ign_reg;
    logic                         m_tvalid_reg;
    logic [RESULT_W-1:0]          m_tdata_reg;
    logic                         m_tuser_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [BIN_WIDTH-1:0]         ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [BIN_WIDTH-1:0]         ram_rdata;
    logic signed [BIN_WIDTH-1:0]  rd_bin;

    logic [CNTW-1:0]              lim_x;
    logic [CNTW-1:0]              cnt_x;
    logic [CNTW-1:0]              used_x;
    logic [CW-1:0]                used;
    logic [CNTW-1:0]              ch_x;
    logic [AW-1:0]                ch_addr;
    logic signed [AMOUNT_W-1:0]   in_amount;
    act_t                         in_act;
    logic                         in_range;
    logic                         acc_ok;
    logic                         accept;
    logic                         out_free;

    // Saturate a wide value to the bin range
    function automatic logic signed [BIN_WIDTH-1:0] sat_bin(input logic signed [EW-1:0] v);
        logic signed [BIN_WIDTH-1:0] r;
        if (v > EW'(BIN_MAX)) begin
            r = BIN_MAX;
        end else if (v < EW'(BIN_MIN)) begin
            r = BIN_MIN;
        end else begin
            r = v[BIN_WIDTH-1:0];
        end
        return r;
    endfunction

    // Saturate a bin value to the result range
    function automatic logic [RESULT_W-1:0] to_out(input logic signed [BIN_WIDTH-1:0] v);
        logic signed [OXW-1:0] vx;
        logic [RESULT_W-1:0]   r;
        vx = OXW'(v);
        if (vx > OXW'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (vx < OXW'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = vx[RESULT_W-1:0];
        end
        return r;
    endfunction

    sha_ram #(
        .WIDTH (BIN_WIDTH),
        .DEPTH (CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_bin = $signed(ram_rdata);

    // Channels in use: count limited to the store, zero taken as one
    assign lim_x  = CNTW'(CHANNELS);
    assign cnt_x  = CNTW'(count_reg);
    always_comb begin
        used_x = (cnt_x > lim_x) ? lim_x : cnt_x;
        if (used_x == '0) begin
            used_x = CNTW'(1);
        end
    end
    assign used = used_x[CW-1:0];

    // Decode the request
    assign ch_x      = CNTW'(s_tdata[CHAN_W-1:0]);
    assign ch_addr   = ch_x[AW-1:0];
    assign in_amount = $signed(s_tdata[CHAN_W +: AMOUNT_W]);
    assign in_act    = act_t'(s_tuser);
    assign in_range  = (ch_x < lim_x);
    assign acc_ok    = enable_reg && (ch_x < used_x);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = ch_addr;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
            end
            ST_IDLE: begin
                if (accept && in_act == ACT_SET && in_range) begin
                    ram_we    = 1'b1;
                    ram_waddr = ch_addr;
                    ram_wdata = sat_bin(EW'(in_amount));
                end
                if (in_act == ACT_MAX) begin
                    ram_raddr = '0;
                end
            end
            ST_ACC: begin
                ram_we    = 1'b1;
                ram_wdata = sat_bin(EW'(rd_bin) + EW'(amount_reg));
            end
            ST_SCAN: begin
                ram_raddr = idx_reg[AW-1:0];
            end
            default: begin
                ram_raddr = addr_reg;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            count_reg  <= SHA_DEF_CHANNEL_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_COUNT:  count_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            clr_emit_reg <= 1'b0;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Raise the result when staged, drop it once taken
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                // Sweep zeros through the store
                ST_CLEAR: begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg[AW-1:0] == LAST_ADDR) begin
                        state_reg <= clr_emit_reg ? ST_DONE : ST_IDLE;
                    end
                end
                // Take a request and start its work
                ST_IDLE: begin
                    if (accept) begin
                        addr_reg   <= ch_addr;
                        amount_reg <= in_amount;
                        value_reg  <= '0;
                        ign_reg    <= (in_act == ACT_ACC) && !acc_ok;
                        case (in_act)
                            ACT_ACC: begin
                                state_reg <= acc_ok ? ST_ACC : ST_DONE;
                            end
                            ACT_READ: begin
                                state_reg <= in_range ? ST_READ : ST_DONE;
                            end
                            ACT_CLEAR: begin
                                idx_reg      <= '0;
                                clr_emit_reg <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            ACT_MAX: begin
                                idx_reg   <= CW'(1);
                                first_reg <= 1'b1;
                                state_reg <= ST_SCAN;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                // Write back happens in the RAM steering
                ST_ACC: begin
                    state_reg <= ST_DONE;
                end
                ST_READ: begin
                    value_reg <= rd_bin;
                    state_reg <= ST_DONE;
                end
                // Fold one bin per cycle into the running maximum
                ST_SCAN: begin
                    first_reg <= 1'b0;
                    if (first_reg || rd_bin > value_reg) begin
                        value_reg <= rd_bin;
                    end
                    if (idx_reg < used) begin
                        idx_reg <= idx_reg + CW'(1);
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                // Stage the result once the output slot is free
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= to_out(value_reg);
                        m_tuser_reg  <= ign_reg;
                        clr_emit_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/sha_checker.sv
`timescale 1ns / 1ps
`include "spectrum_histogram_accumulator_defines.svh"

module sha_checker
    import sha_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [RESULT_W-1:0]    m_tdata,
    input logic                   m_tuser
);

    logic [RESULT_W:0] m_item;

    assign m_item = {m_tuser, m_tdata};

    // A dropped accumulate carries a zero value
    `SHA_ASSERT_NOW(a_ignored_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)

    // A stalled result holds
    `SHA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_item))

    // One request at a time
    `SHA_ASSERT_NEXT(a_one_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // No result appears in the cycle right after a request is taken on an empty output
    `SHA_ASSERT_NEXT(a_min_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

endmodule

bind spectrum_histogram_accumulator sha_checker u_sha_checker (.*);
